>>> hdl/reflow_profile_sequencer_core_macros.svh
// Assertion helpers for the reflow profile sequencer.
`ifndef REFLOW_PROFILE_SEQUENCER_CORE_MACROS_SVH
`define REFLOW_PROFILE_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rps assertion failed");
// next-cycle implication
`define RPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rps assertion failed");
`else
`define RPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/rps_pkg.sv
`default_nettype none

package rps_pkg;

  localparam int TIME_BITS = 10;
  localparam int TEMP_BITS = 10;
  localparam int PROF_BITS = TIME_BITS + TEMP_BITS;
  localparam int PROD_BITS = TIME_BITS + TEMP_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = PROF_BITS;
  localparam int MTEMP_BITS = 12;
  localparam int SP_BITS = 12;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [PROF_BITS-1:0] PREHEAT_RST  = PROF_BITS'(153780);
  localparam logic [PROF_BITS-1:0] SOAK_RST     = PROF_BITS'(204920);
  localparam logic [PROF_BITS-1:0] REFLOW_RST   = PROF_BITS'(235570);
  localparam logic [PROF_BITS-1:0] DWELL_RST    = PROF_BITS'(261160);
  localparam logic [PROF_BITS-1:0] COOLDOWN_RST = PROF_BITS'(102460);
  localparam logic [9:0] START_TEMP_RST = 10'd20;
  localparam logic [9:0] END_HOLD_RST   = 10'd30;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PREHEAT    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOAK       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REFLOW     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DWELL      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_TEMP = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_HOLD   = 3'd6;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PREHEAT  = 3'd1,
    PH_SOAK     = 3'd2,
    PH_REFLOW   = 3'd3,
    PH_DWELL    = 3'd4,
    PH_COOLDOWN = 3'd5,
    PH_END      = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAMP,
    ST_LAUNCH,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/reflow_profile_sequencer_core.sv
`default_nettype none
// A transaction runs RAMP, LAUNCH, DIV, DONE in a heating phase with nonzero duration,
// and RAMP, DONE otherwise (idle, end, or a zero-duration phase).
// Input stalls until the transaction is done; the 20-step bit-serial ramp divider dominates.
// The input takes a new transaction while a finished result still waits on the output.
// Reset (synchronous, active low): phase idle, timer zero, profile registers to defaults.

`include "reflow_profile_sequencer_core_macros.svh"

module reflow_profile_sequencer_core import rps_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_op,
  input  wire logic signed [MTEMP_BITS-1:0] in_measured_temp,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    out_phase,
  output logic signed [SP_BITS-1:0]     out_setpoint,
  output logic                          out_heater_forced_off,
  output logic                          out_alarm_pulse,
  output logic                          out_running
);

  logic [PROF_BITS-1:0] prof_preheat_r, prof_soak_r, prof_reflow_r;
  logic [PROF_BITS-1:0] prof_dwell_r, prof_cooldown_r;
  logic [9:0]           start_temp_r, end_hold_r;

  seq_state_t           state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] sec_r, sec_nxt;
  logic                 alarm_r, alarm_nxt;

  logic [PROF_BITS-1:0] prof_sel;
  logic [TEMP_BITS-1:0] tgt_sel, beg_sel;
  logic [TIME_BITS-1:0] dur_sel;
  logic                 heating;

  logic [TEMP_BITS-1:0] tgt_r, beg_r;
  logic [PROD_BITS-1:0] prod_r;
  logic                 neg_r, zdur_r;
  logic [TIME_BITS-1:0] dur_r;
  logic signed [SP_BITS-1:0] sp_r, sp_nxt;

  logic                 in_fire, out_fire, out_load, div_start;
  logic [TIME_BITS-1:0] sec_inc, hold;
  logic signed [TEMP_BITS:0] diff;
  logic [TEMP_BITS-1:0] diff_mag;

  div_stat_t            div_stat;
  logic [PROD_BITS-1:0] div_q;
  logic signed [SUM_BITS-1:0] q_s, sum;

  logic                 out_valid_r;
  logic [2:0]           out_phase_r;
  logic signed [SP_BITS-1:0] out_sp_r;
  logic                 out_alarm_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prof_preheat_r  <= PREHEAT_RST;
      prof_soak_r     <= SOAK_RST;
      prof_reflow_r   <= REFLOW_RST;
      prof_dwell_r    <= DWELL_RST;
      prof_cooldown_r <= COOLDOWN_RST;
      start_temp_r    <= START_TEMP_RST;
      end_hold_r      <= END_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PREHEAT:    prof_preheat_r  <= cfg_wdata;
        CFG_SOAK:       prof_soak_r     <= cfg_wdata;
        CFG_REFLOW:     prof_reflow_r   <= cfg_wdata;
        CFG_DWELL:      prof_dwell_r    <= cfg_wdata;
        CFG_COOLDOWN:   prof_cooldown_r <= cfg_wdata;
        CFG_START_TEMP: start_temp_r    <= cfg_wdata[9:0];
        CFG_END_HOLD:   end_hold_r      <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // profile and begin temperature of the phase held in phase_r
  always_comb begin
    heating  = 1'b1;
    prof_sel = '0;
    beg_sel  = '0;
    unique case (phase_r)
      PH_PREHEAT: begin
        prof_sel = prof_preheat_r;
        beg_sel  = start_temp_r;
      end
      PH_SOAK: begin
        prof_sel = prof_soak_r;
        beg_sel  = prof_preheat_r[PROF_BITS-1:TIME_BITS];
      end
      PH_REFLOW: begin
        prof_sel = prof_reflow_r;
        beg_sel  = prof_soak_r[PROF_BITS-1:TIME_BITS];
      end
      PH_DWELL: begin
        prof_sel = prof_dwell_r;
        beg_sel  = prof_reflow_r[PROF_BITS-1:TIME_BITS];
      end
      PH_COOLDOWN: begin
        prof_sel = prof_cooldown_r;
        beg_sel  = prof_dwell_r[PROF_BITS-1:TIME_BITS];
      end
      default: heating = 1'b0;
    endcase
  end

  assign tgt_sel = prof_sel[PROF_BITS-1:TIME_BITS];
  assign dur_sel = prof_sel[TIME_BITS-1:0];
  assign sec_inc = (sec_r != TIME_MAX) ? sec_r + 1'b1 : sec_r;
  assign hold    = (end_hold_r == '0) ? TIME_BITS'(1) : TIME_BITS'(end_hold_r);

  // phase step for one transaction
  always_comb begin
    phase_nxt = phase_r;
    sec_nxt   = sec_r;
    alarm_nxt = alarm_r;
    if (in_fire) begin
      alarm_nxt = 1'b0;
      unique case (in_op)
        OP_START: begin
          if (phase_r == PH_IDLE) begin
            phase_nxt = PH_PREHEAT;
            sec_nxt   = '0;
          end
        end
        OP_STOP: begin
          if (phase_r != PH_IDLE) begin
            phase_nxt = PH_END;
            sec_nxt   = '0;
          end
        end
        OP_TICK: begin
          sec_nxt = sec_inc;
          if (heating) begin
            if (sec_inc >= dur_sel &&
                in_measured_temp >= $signed({2'b00, tgt_sel})) begin
              alarm_nxt = (phase_r == PH_COOLDOWN);
              phase_nxt = phase_t'(phase_r + 3'd1);
              sec_nxt   = '0;
            end
          end else if (phase_r == PH_END) begin
            if (sec_inc == hold) begin
              phase_nxt = PH_IDLE;
              sec_nxt   = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sec_r   <= '0;
      alarm_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sec_r   <= sec_nxt;
      alarm_r <= alarm_nxt;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_RAMP;
      ST_RAMP:   state_nxt = (heating && dur_sel != '0) ? ST_LAUNCH : ST_DONE;
      ST_LAUNCH: state_nxt = ST_DIV;
      ST_DIV:    if (div_stat.done) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_LAUNCH: div_start = 1'b1;
      ST_DONE:   out_load  = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // slope numerator: |t * (target - begin)|
  assign diff     = $signed({1'b0, tgt_sel}) - $signed({1'b0, beg_sel});
  assign diff_mag = diff[TEMP_BITS] ? TEMP_BITS'(-diff) : diff[TEMP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_RAMP) begin
      prod_r <= PROD_BITS'(sec_r) * PROD_BITS'(diff_mag);
      neg_r  <= diff[TEMP_BITS];
      tgt_r  <= tgt_sel;
      beg_r  <= beg_sel;
      dur_r  <= dur_sel;
      zdur_r <= (dur_sel == '0);
    end
  end

  rps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (dur_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // quotient magnitude truncates toward zero; apply sign, add begin, clamp
  assign q_s = neg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign sum = q_s + $signed({(SUM_BITS-TEMP_BITS)'(0), beg_r});

  always_comb begin
    sp_nxt = sp_r;
    if (state_r == ST_RAMP) begin
      if (!heating) sp_nxt = '0;
      else if (dur_sel == '0) sp_nxt = $signed({2'b00, tgt_sel});
    end else if (state_r == ST_DIV && div_stat.done && !zdur_r) begin
      if (sum > $signed({(SUM_BITS-TEMP_BITS)'(0), tgt_r}))
        sp_nxt = $signed({2'b00, tgt_r});
      else if (sum < -$signed(SUM_BITS'(2048)))
        sp_nxt = -$signed(SP_BITS'(2048));
      else
        sp_nxt = sum[SP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sp_r <= sp_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_phase_r <= phase_r;
      out_sp_r    <= sp_r;
      out_alarm_r <= alarm_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_phase             = out_phase_r;
  assign out_setpoint          = out_sp_r;
  assign out_heater_forced_off = (out_phase_r == PH_END);
  assign out_alarm_pulse       = out_alarm_r;
  assign out_running           = (out_phase_r != PH_IDLE);

  `RPS_ASSERT_IMP(a_alarm_in_end, clk, rst_n, out_valid && out_alarm_pulse, out_phase == PH_END)
  `RPS_ASSERT_IMP(a_idle_no_sp, clk, rst_n, out_valid && !out_running, out_setpoint == '0)
  `RPS_ASSERT_IMP(a_div_active, clk, rst_n, state_r == ST_DIV, div_stat.busy || div_stat.done)
  `RPS_ASSERT_NXT(a_fire_ramp, clk, rst_n, in_fire, state_r == ST_RAMP)

endmodule

`default_nettype wire

>>> hdl/rps_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module rps_div import rps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [PROD_BITS-1:0] dividend,
  input  wire logic [TIME_BITS-1:0] divisor,
  output div_stat_t                 stat,
  output logic      [PROD_BITS-1:0] quotient
);

  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [PROD_BITS-1:0]    q_r, q_nxt;
  logic [TIME_BITS-1:0]    rem_r, rem_nxt;
  logic [TIME_BITS-1:0]    div_r, div_nxt;
  logic [TIME_BITS:0]      rem_sh;
  logic [TIME_BITS:0]      rem_sub;
  logic                    fits;

  assign rem_sh  = {rem_r, q_r[PROD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign fits    = (rem_sh >= {1'b0, div_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      cnt_nxt = DIV_CNT_BITS'(PROD_BITS);
      q_nxt   = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_BITS'(1));
      q_nxt    = {q_r[PROD_BITS-2:0], fits};
      // remainder stays below the divisor, so the top bit drops
      rem_nxt  = fits ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

`default_nettype wire
